FILE: rtl/price_level_order_book_assert.svh
// ----------------------------------------------------------------------------
// price level order book assertion macros
// clocked, reset-qualified property wrappers used by the checker
// ----------------------------------------------------------------------------
`ifndef PRICE_LEVEL_ORDER_BOOK_ASSERT_SVH
`define PRICE_LEVEL_ORDER_BOOK_ASSERT_SVH

// plain property under clock and active-low reset
`define PLOB_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("order book assertion failed");

// same-cycle implication
`define PLOB_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  `PLOB_ASSERT(lbl, clk, rst_n, (ante) |-> (cons))

// next-cycle implication
`define PLOB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  `PLOB_ASSERT(lbl, clk, rst_n, (ante) |=> (cons))

`endif

FILE: rtl/plob_pkg.sv
// ----------------------------------------------------------------------------
// plob_pkg
// shared constants, action codes and controller/datapath interface types
// ----------------------------------------------------------------------------
package plob_pkg;

  localparam int PRICE_LEVELS = 101;
  localparam int ADDR_W       = $clog2(PRICE_LEVELS);
  localparam int ACT_W        = 2;
  localparam int PRICE_W      = 7;
  localparam int SIZE_W       = 32;
  localparam int TS_W         = 48;

  localparam logic [ACT_W-1:0] ACT_DELTA = 2'd0;
  localparam logic [ACT_W-1:0] ACT_SNAP  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_QUERY = 2'd2;

  localparam logic [PRICE_W-1:0] BID_DEFAULT = '0;
  localparam logic [PRICE_W-1:0] ASK_DEFAULT = PRICE_W'(PRICE_LEVELS - 1);

  typedef struct packed {
    logic capture;
    logic exec;
    logic scan_start;
    logic scan_rd;
    logic emit;
    logic emit_query;
  } plob_cmd_t;

  typedef struct packed {
    logic query;
    logic rescan;
    logic scan_end;
  } plob_sts_t;

endpackage

FILE: rtl/plob_ram.sv
// ----------------------------------------------------------------------------
// plob_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module plob_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 101
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/plob_ctrl.sv
// ----------------------------------------------------------------------------
// plob_ctrl
// transaction sequencer: execute, query read wait, level scan and drain
// ----------------------------------------------------------------------------
module plob_ctrl import plob_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  plob_sts_t sts,
  output logic      busy,
  output plob_cmd_t cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_QUERY = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_DRAIN = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (sts.query) begin
          state_nxt = S_QUERY;
        end else if (sts.rescan) begin
          cmd.scan_start = 1'b1;
          state_nxt      = S_SCAN;
        end else begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_QUERY: begin
        cmd.emit       = 1'b1;
        cmd.emit_query = 1'b1;
        state_nxt      = S_IDLE;
      end
      S_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (sts.scan_end) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        cmd.emit  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

FILE: rtl/plob_dp.sv
// ----------------------------------------------------------------------------
// plob_dp
// size tables with per-level valid bits, best price and time registers,
// scan logic and result registers
// ----------------------------------------------------------------------------
module plob_dp import plob_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  plob_cmd_t          cmd,
  output plob_sts_t          sts,
  input  logic [ACT_W-1:0]   in_action,
  input  logic               in_side,
  input  logic [PRICE_W-1:0] in_price,
  input  logic [SIZE_W-1:0]  in_size,
  input  logic [PRICE_W-1:0] in_given_best_bid,
  input  logic [PRICE_W-1:0] in_given_best_ask,
  input  logic [TS_W-1:0]    in_timestamp,
  input  logic               in_snapshot_first,
  input  logic               in_snapshot_last,
  output logic               out_valid,
  output logic [SIZE_W-1:0]  out_level_size,
  output logic [PRICE_W-1:0] out_best_bid,
  output logic [PRICE_W-1:0] out_best_ask,
  output logic [TS_W-1:0]    out_last_message_time,
  output logic               out_price_error
);

  // captured transaction
  logic [ACT_W-1:0]   act_r;
  logic               side_r;
  logic [PRICE_W-1:0] price_r;
  logic [SIZE_W-1:0]  size_r;
  logic [PRICE_W-1:0] gbid_r;
  logic [PRICE_W-1:0] gask_r;
  logic [TS_W-1:0]    ts_r;
  logic               first_r;
  logic               last_r;

  logic               price_ok;
  logic               err;
  logic               do_write;
  logic [ADDR_W-1:0]  idx;
  logic [ADDR_W-1:0]  raddr;

  logic [PRICE_LEVELS-1:0] bid_vld_r;
  logic [PRICE_LEVELS-1:0] bid_vld_nxt;
  logic [PRICE_LEVELS-1:0] ask_vld_r;
  logic [PRICE_LEVELS-1:0] ask_vld_nxt;

  logic [SIZE_W-1:0]  bid_rdata;
  logic [SIZE_W-1:0]  ask_rdata;
  logic               q_vld_r;

  logic [ADDR_W-1:0]  scan_cnt_r;
  logic [ADDR_W-1:0]  scan_idx_r;
  logic               scan_pend_r;
  logic               sbid_vld_r;
  logic               sask_vld_r;
  logic               found_r;
  logic               found_nxt;

  logic [PRICE_W-1:0] best_bid_r;
  logic [PRICE_W-1:0] best_bid_nxt;
  logic [PRICE_W-1:0] best_ask_r;
  logic [PRICE_W-1:0] best_ask_nxt;
  logic [TS_W-1:0]    last_msg_r;
  logic [TS_W-1:0]    last_msg_nxt;

  logic               out_valid_r;
  logic [SIZE_W-1:0]  out_level_size_r;
  logic [PRICE_W-1:0] out_best_bid_r;
  logic [PRICE_W-1:0] out_best_ask_r;
  logic [TS_W-1:0]    out_last_msg_r;
  logic               out_err_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_r   <= in_action;
      side_r  <= in_side;
      price_r <= in_price;
      size_r  <= in_size;
      gbid_r  <= in_given_best_bid;
      gask_r  <= in_given_best_ask;
      ts_r    <= in_timestamp;
      first_r <= in_snapshot_first;
      last_r  <= in_snapshot_last;
    end
  end

  assign price_ok = (32'(price_r) < PRICE_LEVELS);
  assign idx      = ADDR_W'(price_r);
  assign err      = (act_r == ACT_DELTA || act_r == ACT_SNAP || act_r == ACT_QUERY)
                    && !price_ok;
  assign do_write = cmd.exec && price_ok && (act_r == ACT_DELTA || act_r == ACT_SNAP);

  assign sts.query    = (act_r == ACT_QUERY) && price_ok;
  assign sts.rescan   = (act_r == ACT_SNAP) && price_ok && last_r;
  assign sts.scan_end = (scan_cnt_r == ADDR_W'(PRICE_LEVELS - 1));

  // valid bits: a level never written since reset or snapshot start reads zero
  always_comb begin
    bid_vld_nxt = bid_vld_r;
    ask_vld_nxt = ask_vld_r;
    if (do_write) begin
      if (act_r == ACT_SNAP && first_r) begin
        bid_vld_nxt = '0;
        ask_vld_nxt = '0;
      end
      if (side_r) begin
        ask_vld_nxt[idx] = 1'b1;
      end else begin
        bid_vld_nxt[idx] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bid_vld_r <= '0;
      ask_vld_r <= '0;
    end else begin
      bid_vld_r <= bid_vld_nxt;
      ask_vld_r <= ask_vld_nxt;
    end
  end

  assign raddr = cmd.scan_rd ? scan_cnt_r : idx;

  plob_ram #(
    .WIDTH (SIZE_W),
    .DEPTH (PRICE_LEVELS)
  ) u_bid_ram (
    .clk   (clk),
    .we    (do_write && !side_r),
    .waddr (idx),
    .wdata (size_r),
    .raddr (raddr),
    .rdata (bid_rdata)
  );

  plob_ram #(
    .WIDTH (SIZE_W),
    .DEPTH (PRICE_LEVELS)
  ) u_ask_ram (
    .clk   (clk),
    .we    (do_write && side_r),
    .waddr (idx),
    .wdata (size_r),
    .raddr (raddr),
    .rdata (ask_rdata)
  );

  // valid bits aligned with registered ram read
  always_ff @(posedge clk) begin
    q_vld_r    <= side_r ? ask_vld_r[idx] : bid_vld_r[idx];
    sbid_vld_r <= bid_vld_r[scan_cnt_r];
    sask_vld_r <= ask_vld_r[scan_cnt_r];
    scan_idx_r <= scan_cnt_r;
    if (cmd.scan_start) begin
      scan_cnt_r <= '0;
    end else if (cmd.scan_rd) begin
      scan_cnt_r <= scan_cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_pend_r <= 1'b0;
    end else begin
      scan_pend_r <= cmd.scan_rd;
    end
  end

  // best prices and message time
  always_comb begin
    best_bid_nxt = best_bid_r;
    best_ask_nxt = best_ask_r;
    last_msg_nxt = last_msg_r;
    found_nxt    = found_r;
    if (do_write) begin
      last_msg_nxt = ts_r;
      if (act_r == ACT_DELTA) begin
        best_bid_nxt = gbid_r;
        best_ask_nxt = gask_r;
      end
    end
    if (cmd.scan_start) begin
      best_bid_nxt = BID_DEFAULT;
      best_ask_nxt = ASK_DEFAULT;
      found_nxt    = 1'b0;
    end
    if (scan_pend_r) begin
      if (sbid_vld_r && bid_rdata != '0) begin
        best_bid_nxt = PRICE_W'(scan_idx_r);
      end
      if (!found_r && sask_vld_r && ask_rdata != '0) begin
        best_ask_nxt = PRICE_W'(scan_idx_r);
        found_nxt    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_bid_r <= BID_DEFAULT;
      best_ask_r <= ASK_DEFAULT;
      last_msg_r <= '0;
      found_r    <= 1'b0;
    end else begin
      best_bid_r <= best_bid_nxt;
      best_ask_r <= best_ask_nxt;
      last_msg_r <= last_msg_nxt;
      found_r    <= found_nxt;
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_level_size_r <= (cmd.emit_query && q_vld_r) ?
                          (side_r ? ask_rdata : bid_rdata) : '0;
      out_best_bid_r   <= best_bid_nxt;
      out_best_ask_r   <= best_ask_nxt;
      out_last_msg_r   <= last_msg_nxt;
      out_err_r        <= err;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_level_size        = out_level_size_r;
  assign out_best_bid          = out_best_bid_r;
  assign out_best_ask          = out_best_ask_r;
  assign out_last_message_time = out_last_msg_r;
  assign out_price_error       = out_err_r;

endmodule

FILE: rtl/price_level_order_book.sv
// ----------------------------------------------------------------------------
// price_level_order_book
// delta and snapshot level, and invalid-price or unused-action transactions:
// result strobe registered from the execute state; query: strobe after the
// query read wait state; last snapshot level: strobe after the drain state
// that follows the 101-level ram scan; busy stays high until the strobe
// results cannot be stalled; out_valid is a one-cycle strobe
// sync reset empties both tables at once through per-level valid bits
// ----------------------------------------------------------------------------
module price_level_order_book import plob_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [ACT_W-1:0]   in_action,
  input  logic               in_side,
  input  logic [PRICE_W-1:0] in_price,
  input  logic [SIZE_W-1:0]  in_size,
  input  logic [PRICE_W-1:0] in_given_best_bid,
  input  logic [PRICE_W-1:0] in_given_best_ask,
  input  logic [TS_W-1:0]    in_timestamp,
  input  logic               in_snapshot_first,
  input  logic               in_snapshot_last,
  output logic               out_valid,
  output logic [SIZE_W-1:0]  out_level_size,
  output logic [PRICE_W-1:0] out_best_bid,
  output logic [PRICE_W-1:0] out_best_ask,
  output logic [TS_W-1:0]    out_last_message_time,
  output logic               out_price_error
);

  plob_cmd_t cmd;
  plob_sts_t sts;

  plob_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .busy  (busy),
    .cmd   (cmd)
  );

  plob_dp u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .sts                   (sts),
    .in_action             (in_action),
    .in_side               (in_side),
    .in_price              (in_price),
    .in_size               (in_size),
    .in_given_best_bid     (in_given_best_bid),
    .in_given_best_ask     (in_given_best_ask),
    .in_timestamp          (in_timestamp),
    .in_snapshot_first     (in_snapshot_first),
    .in_snapshot_last      (in_snapshot_last),
    .out_valid             (out_valid),
    .out_level_size        (out_level_size),
    .out_best_bid          (out_best_bid),
    .out_best_ask          (out_best_ask),
    .out_last_message_time (out_last_message_time),
    .out_price_error       (out_price_error)
  );

endmodule

FILE: rtl/plob_checker.sv
// ----------------------------------------------------------------------------
// plob_checker
// port-level transaction timing checks, bound to the top level
// ----------------------------------------------------------------------------
`include "price_level_order_book_assert.svh"

module plob_checker import plob_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              out_valid,
  input logic [SIZE_W-1:0] out_level_size,
  input logic              out_price_error
);

  `PLOB_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
  `PLOB_ASSERT_IMPL(a_strobe_idle, clk, rst_n, out_valid, !busy)
  `PLOB_ASSERT_NEXT(a_strobe_gap, clk, rst_n, out_valid, !out_valid)
  `PLOB_ASSERT_IMPL(a_err_no_size, clk, rst_n, out_valid && out_price_error, out_level_size == '0)
  `PLOB_ASSERT_IMPL(a_done_result, clk, rst_n, $fell(busy) && $past(rst_n), out_valid)

endmodule

bind price_level_order_book plob_checker u_plob_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_level_size  (out_level_size),
  .out_price_error (out_price_error)
);

FILE: sim/price_level_order_book_test.sv
// ----------------------------------------------------------------------------
// price_level_order_book_test
// drives deltas, snapshot sequences, size queries and invalid-price or
// unused-action noise through the command port with random idle gaps,
// predicts every result with a scoreboard that mirrors the bid and ask
// tables, and checks each result strobe field by field
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module price_level_order_book_test import plob_pkg::*;;

  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
  localparam int TARGET_ITEMS = 1400;
  localparam int STALL_LIMIT  = 2000;
  localparam int SCAN_CYCLES  = 110;

  typedef struct {
    logic [ACT_W-1:0]   action;
    logic               side;
    logic [PRICE_W-1:0] price;
    logic [SIZE_W-1:0]  amount;
    logic [PRICE_W-1:0] given_bid;
    logic [PRICE_W-1:0] given_ask;
    logic [TS_W-1:0]    stamp;
    logic               snap_first;
    logic               snap_last;
  } book_order_t;

  typedef struct {
    logic [SIZE_W-1:0]  level_size;
    logic [PRICE_W-1:0] best_bid;
    logic [PRICE_W-1:0] best_ask;
    logic [TS_W-1:0]    last_time;
    logic               price_error;
  } book_view_t;

  class book_scoreboard;
    bit [SIZE_W-1:0]  bid_tbl [PRICE_LEVELS];
    bit [SIZE_W-1:0]  ask_tbl [PRICE_LEVELS];
    bit [PRICE_W-1:0] best_bid;
    bit [PRICE_W-1:0] best_ask;
    bit [TS_W-1:0]    last_time;
    book_view_t       pending [$];
    int               mismatches;
    int               checked;

    function new();
      foreach (bid_tbl[i]) bid_tbl[i] = '0;
      foreach (ask_tbl[i]) ask_tbl[i] = '0;
      best_bid   = BID_DEFAULT;
      best_ask   = ASK_DEFAULT;
      last_time  = '0;
      mismatches = 0;
      checked    = 0;
    endfunction

    function void note_input(book_order_t t);
      book_view_t v;
      int p;
      p = int'(t.price);
      v.level_size  = '0;
      v.price_error = 1'b0;
      if (t.action != ACT_UNUSED && p >= PRICE_LEVELS) begin
        v.price_error = 1'b1;
      end else if (t.action == ACT_DELTA) begin
        if (t.side) ask_tbl[p] = t.amount;
        else bid_tbl[p] = t.amount;
        best_bid  = t.given_bid;
        best_ask  = t.given_ask;
        last_time = t.stamp;
      end else if (t.action == ACT_SNAP) begin
        if (t.snap_first) begin
          foreach (bid_tbl[i]) bid_tbl[i] = '0;
          foreach (ask_tbl[i]) ask_tbl[i] = '0;
        end
        if (t.side) ask_tbl[p] = t.amount;
        else bid_tbl[p] = t.amount;
        if (t.snap_last) begin
          // highest nonzero bid, lowest nonzero ask
          best_bid = BID_DEFAULT;
          for (int i = PRICE_LEVELS - 1; i >= 0; i--) begin
            if (bid_tbl[i] != 0) begin
              best_bid = PRICE_W'(i);
              break;
            end
          end
          best_ask = ASK_DEFAULT;
          for (int i = 0; i < PRICE_LEVELS; i++) begin
            if (ask_tbl[i] != 0) begin
              best_ask = PRICE_W'(i);
              break;
            end
          end
        end
        last_time = t.stamp;
      end else if (t.action == ACT_QUERY) begin
        v.level_size = t.side ? ask_tbl[p] : bid_tbl[p];
      end
      v.best_bid  = best_bid;
      v.best_ask  = best_ask;
      v.last_time = last_time;
      pending.push_back(v);
    endfunction

    function void compare_field(string name, logic [TS_W-1:0] want, logic [TS_W-1:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected %0h, actual %0h", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(book_view_t got);
      book_view_t want;
      if (pending.size() == 0) begin
        $error("result with no transaction waiting for it");
        mismatches++;
        return;
      end
      want = pending.pop_front();
      checked++;
      compare_field("level_size", TS_W'(want.level_size), TS_W'(got.level_size));
      compare_field("best_bid", TS_W'(want.best_bid), TS_W'(got.best_bid));
      compare_field("best_ask", TS_W'(want.best_ask), TS_W'(got.best_ask));
      compare_field("last_message_time", want.last_time, got.last_time);
      compare_field("price_error", TS_W'(want.price_error), TS_W'(got.price_error));
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [ACT_W-1:0]   in_action;
  logic               in_side;
  logic [PRICE_W-1:0] in_price;
  logic [SIZE_W-1:0]  in_size;
  logic [PRICE_W-1:0] in_given_best_bid;
  logic [PRICE_W-1:0] in_given_best_ask;
  logic [TS_W-1:0]    in_timestamp;
  logic               in_snapshot_first;
  logic               in_snapshot_last;
  logic               out_valid;
  logic [SIZE_W-1:0]  out_level_size;
  logic [PRICE_W-1:0] out_best_bid;
  logic [PRICE_W-1:0] out_best_ask;
  logic [TS_W-1:0]    out_last_message_time;
  logic               out_price_error;

  book_scoreboard sb = new();
  bit idling_on;
  int n_applied;
  int n_ignored;
  int act_seen [4];
  int stall_cycles;

  price_level_order_book u_top (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_action            (in_action),
    .in_side              (in_side),
    .in_price             (in_price),
    .in_size              (in_size),
    .in_given_best_bid    (in_given_best_bid),
    .in_given_best_ask    (in_given_best_ask),
    .in_timestamp         (in_timestamp),
    .in_snapshot_first    (in_snapshot_first),
    .in_snapshot_last     (in_snapshot_last),
    .out_valid            (out_valid),
    .out_level_size       (out_level_size),
    .out_best_bid         (out_best_bid),
    .out_best_ask         (out_best_ask),
    .out_last_message_time(out_last_message_time),
    .out_price_error      (out_price_error)
  );

  always #10 clk = ~clk;

  function automatic book_order_t mk(
    input logic [ACT_W-1:0] act, input logic side, input logic [PRICE_W-1:0] price,
    input logic [SIZE_W-1:0] amount, input logic [PRICE_W-1:0] gbid,
    input logic [PRICE_W-1:0] gask, input logic [TS_W-1:0] stamp,
    input logic first, input logic last);
    book_order_t t;
    t.action     = act;
    t.side       = side;
    t.price      = price;
    t.amount     = amount;
    t.given_bid  = gbid;
    t.given_ask  = gask;
    t.stamp      = stamp;
    t.snap_first = first;
    t.snap_last  = last;
    return t;
  endfunction

  function automatic logic [PRICE_W-1:0] rand_price();
    if ($urandom_range(99) < 6) return PRICE_W'($urandom_range(PRICE_LEVELS, 127));
    return PRICE_W'($urandom_range(PRICE_LEVELS - 1));
  endfunction

  function automatic logic [SIZE_W-1:0] rand_amount();
    int sel;
    sel = $urandom_range(99);
    if (sel < 20) return '0;
    if (sel < 25) return '1;
    if (sel < 60) return SIZE_W'($urandom_range(1000));
    return $urandom;
  endfunction

  function automatic book_order_t rand_order(input logic [ACT_W-1:0] act);
    book_order_t t;
    t.action     = act;
    t.side       = 1'($urandom_range(1));
    t.price      = rand_price();
    t.amount     = rand_amount();
    t.given_bid  = ($urandom_range(9) == 0) ? PRICE_W'($urandom_range(127))
                                            : PRICE_W'($urandom_range(100));
    t.given_ask  = ($urandom_range(9) == 0) ? PRICE_W'($urandom_range(127))
                                            : PRICE_W'($urandom_range(100));
    t.stamp      = TS_W'({$urandom, $urandom});
    t.snap_first = 1'($urandom_range(1));
    t.snap_last  = 1'($urandom_range(1));
    return t;
  endfunction

  task automatic send_order(input book_order_t t);
    if (idling_on && $urandom_range(99) < 28) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_action         <= t.action;
    in_side           <= t.side;
    in_price          <= t.price;
    in_size           <= t.amount;
    in_given_best_bid <= t.given_bid;
    in_given_best_ask <= t.given_ask;
    in_timestamp      <= t.stamp;
    in_snapshot_first <= t.snap_first;
    in_snapshot_last  <= t.snap_last;
    start             <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_input(t);
    act_seen[t.action]++;
    if (t.action == ACT_UNUSED || t.price >= PRICE_LEVELS) n_ignored++;
    else n_applied++;
  endtask

  // hold off until every result of the sent transactions has come back
  task automatic drain_results();
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    book_view_t got;
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      got.level_size  = out_level_size;
      got.best_bid    = out_best_bid;
      got.best_ask    = out_best_ask;
      got.last_time   = out_last_message_time;
      got.price_error = out_price_error;
      sb.check_result(got);
    end
  end

  always @(posedge clk) begin
    if ((start === 1'b1 && busy === 1'b0) || out_valid === 1'b1) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("[price_level_order_book] ERROR");
      $finish;
    end
  end

  initial begin
    int len;
    bit broken;
    bit mid_drained;
    book_order_t t;
    rst_n             <= 1'b0;
    start             <= 1'b0;
    in_action         <= ACT_DELTA;
    in_side           <= 1'b0;
    in_price          <= '0;
    in_size           <= '0;
    in_given_best_bid <= '0;
    in_given_best_ask <= '0;
    in_timestamp      <= '0;
    in_snapshot_first <= 1'b0;
    in_snapshot_last  <= 1'b0;
    idling_on         = 1'b1;
    mid_drained       = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty book, extreme levels, invalid prices, snapshot corners
    send_order(mk(ACT_QUERY, 0, 0, 0, 0, 0, 0, 0, 0));
    send_order(mk(ACT_QUERY, 1, 100, '1, '1, '1, '1, 0, 0));
    send_order(mk(ACT_DELTA, 0, 0, '1, 0, 100, 1, 0, 0));
    send_order(mk(ACT_DELTA, 1, 100, '1, 127, 127, '1, 1, 1));
    send_order(mk(ACT_QUERY, 0, 0, 0, 0, 0, 0, 1, 1));
    send_order(mk(ACT_QUERY, 1, 100, 0, 0, 0, 0, 0, 0));
    send_order(mk(ACT_DELTA, 0, 101, 32'h1234, 5, 6, 48'h77, 0, 0));
    send_order(mk(ACT_DELTA, 1, 127, 32'h5555_5555, 9, 9, 48'h88, 0, 0));
    send_order(mk(ACT_QUERY, 1, 127, 0, 0, 0, 0, 0, 0));
    send_order(mk(ACT_SNAP, 0, 101, 32'h3, 0, 0, 48'h99, 1, 1));
    send_order(mk(ACT_QUERY, 0, 0, 0, 0, 0, 0, 0, 0));
    send_order(mk(ACT_UNUSED, 1, 127, '1, 127, 127, '1, 1, 1));
    send_order(mk(ACT_SNAP, 0, 50, 7, 3, 4, 48'hAAAA_AAAA_AAAA, 1, 1));
    send_order(mk(ACT_QUERY, 1, 100, 0, 0, 0, 0, 0, 0));
    send_order(mk(ACT_SNAP, 0, 10, 1, 0, 0, 48'h100, 1, 0));
    send_order(mk(ACT_SNAP, 1, 60, 2, 0, 0, 48'h101, 0, 0));
    send_order(mk(ACT_SNAP, 0, 90, 32'h8000_0000, 0, 0, 48'h102, 0, 0));
    send_order(mk(ACT_SNAP, 1, 20, 3, 0, 0, 48'h103, 0, 1));
    send_order(mk(ACT_SNAP, 1, 0, 0, 0, 0, 48'h104, 1, 1));
    send_order(mk(ACT_SNAP, 1, 100, 9, 0, 0, 48'h105, 1, 0));
    send_order(mk(ACT_SNAP, 0, 100, 1, 0, 0, 48'h106, 0, 1));
    send_order(mk(ACT_SNAP, 0, 0, 1, 0, 0, 48'h107, 1, 0));
    send_order(mk(ACT_SNAP, 1, 0, 1, 0, 0, 48'h108, 0, 1));
    send_order(mk(ACT_QUERY, 0, 0, 0, 0, 0, 0, 0, 0));
    send_order(mk(ACT_DELTA, 0, 7'h2A, 32'hAAAA_AAAA, 7'h55, 7'h2A, 48'h5555_5555_5555, 0, 0));
    drain_results();

    // random: deltas, queries, snapshot sequences and noise
    while ((n_applied + n_ignored) < TARGET_ITEMS) begin
      idling_on = !(n_applied >= 600 && n_applied < 900);
      if (!mid_drained && n_applied >= 1000) begin
        drain_results();
        mid_drained = 1'b1;
      end
      case ($urandom_range(99)) inside
        [0:34]:  send_order(rand_order(ACT_DELTA));
        [35:64]: send_order(rand_order(ACT_QUERY));
        [65:89]: begin
          len    = $urandom_range(0, 6);
          broken = ($urandom_range(9) == 0);
          for (int k = 0; k <= len; k++) begin
            t = rand_order(ACT_SNAP);
            t.snap_first = broken ? t.snap_first : (k == 0);
            t.snap_last  = broken ? t.snap_last : (k == len);
            send_order(t);
          end
        end
        default: begin
          t = rand_order(ACT_UNUSED);
          if ($urandom_range(1)) begin
            t.action = ACT_W'($urandom_range(2));
            t.price  = PRICE_W'($urandom_range(PRICE_LEVELS, 127));
          end
          send_order(t);
        end
      endcase
    end
    start <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SCAN_CYCLES) @(posedge clk);

    $display("sent %0d transactions: %0d deltas, %0d snapshot levels, %0d queries, %0d unused",
             n_applied + n_ignored, act_seen[ACT_DELTA], act_seen[ACT_SNAP],
             act_seen[ACT_QUERY], act_seen[ACT_UNUSED]);
    $display("%0d ignored for invalid price or action, %0d results checked",
             n_ignored, sb.checked);
    if (sb.mismatches == 0) begin
      $display("[price_level_order_book] OK");
    end else begin
      $display("[price_level_order_book] ERROR");
    end
    $finish;
  end

endmodule
